// ===== rtl/blt_pkg.sv =====
`default_nettype none

package blt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int HANDLE_BITS = 16;
    localparam int PORT_BITS   = 16;
    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 2;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD        = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_FIND       = 3'd2,
        OP_LIST_SCENE = 3'd3,
        OP_LIST_PROV  = 3'd4
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_LINKED    = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        M_PAIR,
        M_SCENE,
        M_PROV
    } t_match;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] provider;
        logic [HANDLE_BITS-1:0] scene;
        logic [HANDLE_BITS-1:0] slot;
    } t_link;

    typedef struct packed {
        t_status status;
        logic    found;
        t_link   link;
        logic    last;
    } t_result;

    // storage port request from the sequencer
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        t_link               wdata;
        logic                re;
        logic [IDX_BITS-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== rtl/blt_if.sv =====
`default_nettype none

interface blt_in_if;
    import blt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     operation;
    logic [PORT_BITS-1:0]   provider_buffer;
    logic [PORT_BITS-1:0]   scene_id;
    logic [PORT_BITS-1:0]   slot_id;

    modport source (output valid, operation, provider_buffer, scene_id, slot_id,
                    input ready);
    modport sink   (input valid, operation, provider_buffer, scene_id, slot_id,
                    output ready);
endinterface

interface blt_out_if;
    import blt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic                   found;
    logic [PORT_BITS-1:0]   link_provider;
    logic [PORT_BITS-1:0]   link_scene;
    logic [PORT_BITS-1:0]   link_slot;
    logic                   last;

    modport source (output valid, status, found, link_provider, link_scene, link_slot,
                    last, input ready);
    modport sink   (input valid, status, found, link_provider, link_scene, link_slot,
                    last, output ready);
endinterface

`default_nettype wire

// ===== rtl/blt_compare.sv =====
`default_nettype none

module blt_compare (
    input  blt_pkg::t_link  i_entry,
    input  blt_pkg::t_link  i_key,
    input  blt_pkg::t_match i_mode,
    output logic            o_hit
);
    import blt_pkg::*;

    always_comb begin
        case (i_mode)
            M_PAIR:  o_hit = (i_entry.scene == i_key.scene) && (i_entry.slot == i_key.slot);
            M_SCENE: o_hit = (i_entry.scene == i_key.scene);
            M_PROV:  o_hit = (i_entry.provider == i_key.provider);
            default: o_hit = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/blt_store.sv =====
`default_nettype none

module blt_store (
    input  logic              i_clk,
    input  blt_pkg::t_mem_req i_req,
    output blt_pkg::t_link    o_rd_data
);
    import blt_pkg::*;

    t_link r_mem [TABLE_DEPTH];
    t_link r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        // read data holds while no read is issued
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/buffer_link_table.sv =====
// Add, find and list scan the stored links one per cycle (a list scan waits
// while the output is stalled); a pair match ends the scan early.
// Remove reports at the match, then moves later entries down.
// One item at a time: a new request is taken only once the block is back in
// idle, after its result and any shift, as the single storage read port
// serves every scan. Reset: link count cleared, storage not cleared.
`default_nettype none

module buffer_link_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    blt_in_if.sink    i_in,
    blt_out_if.source o_out
);
    import blt_pkg::*;

    // sequencer state
    t_state                 r_state, n_state;
    logic [OP_BITS-1:0]     r_op, n_op;
    t_link                  r_key, n_key;
    logic [CNT_BITS-1:0]    r_count, n_count;

    // scan pointer and read pipeline tag
    logic [CNT_BITS-1:0]    r_ptr, n_ptr;
    logic                   r_dv, n_dv;
    logic [IDX_BITS-1:0]    r_didx, n_didx;

    // pair match found during scan
    logic                   r_hit, n_hit;
    logic [IDX_BITS-1:0]    r_hit_idx, n_hit_idx;
    t_link                  r_hit_link, n_hit_link;

    // list match held back until we know whether it is the final one
    logic                   r_pend_v, n_pend_v;
    t_link                  r_pend, n_pend;

    // output register
    logic                   r_ov, n_ov;
    t_result                r_res, n_res;

    t_mem_req               mem_req;
    t_link                  rd_data;
    t_match                 mode;
    logic                   cmp_hit;
    logic                   out_free;
    logic                   stall;

    blt_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // the one compare unit, reused for every entry of every scan
    blt_compare u_compare (
        .i_entry (rd_data),
        .i_key   (r_key),
        .i_mode  (mode),
        .o_hit   (cmp_hit)
    );

    always_comb begin
        case (t_op'(r_op))
            OP_LIST_SCENE: mode = M_SCENE;
            OP_LIST_PROV:  mode = M_PROV;
            default:       mode = M_PAIR;
        endcase
    end

    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_count    = r_count;
        n_ptr      = r_ptr;
        n_dv       = r_dv;
        n_didx     = r_didx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_link = r_hit_link;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_ov       = r_ov && !o_out.ready;
        n_res      = r_res;
        stall      = 1'b0;

        mem_req       = '0;
        mem_req.raddr = r_ptr[IDX_BITS-1:0];

        i_in.ready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op           = i_in.operation;
                    n_key.provider = HANDLE_BITS'(i_in.provider_buffer);
                    n_key.scene    = HANDLE_BITS'(i_in.scene_id);
                    n_key.slot     = HANDLE_BITS'(i_in.slot_id);
                    n_ptr          = '0;
                    n_dv           = 1'b0;
                    n_hit          = 1'b0;
                    n_pend_v       = 1'b0;
                    case (t_op'(i_in.operation))
                        OP_ADD, OP_REMOVE, OP_FIND, OP_LIST_SCENE, OP_LIST_PROV: begin
                            n_state = S_SCAN;
                        end
                        // undefined codes skip the scan and report not found
                        default: n_state = S_FINAL;
                    endcase
                end
            end

            S_SCAN: begin
                // check the entry read last cycle
                if (r_dv && cmp_hit) begin
                    if (mode == M_PAIR) begin
                        // pairs are unique: stop at the first match
                        n_hit      = 1'b1;
                        n_hit_idx  = r_didx;
                        n_hit_link = rd_data;
                        n_dv       = 1'b0;
                        n_state    = S_FINAL;
                    end else if (r_pend_v) begin
                        // a later match exists, so the held one is not last
                        if (out_free) begin
                            n_ov   = 1'b1;
                            n_res  = '{status: ST_OK, found: 1'b1, link: r_pend,
                                       last: 1'b0};
                            n_pend = rd_data;
                        end else begin
                            stall = 1'b1;
                        end
                    end else begin
                        n_pend_v = 1'b1;
                        n_pend   = rd_data;
                    end
                end
                // issue the next read unless the result path is blocked
                if (n_state == S_SCAN && !stall) begin
                    if (r_ptr < r_count) begin
                        mem_req.re = 1'b1;
                        n_ptr      = r_ptr + CNT_BITS'(1);
                        n_dv       = 1'b1;
                        n_didx     = r_ptr[IDX_BITS-1:0];
                    end else begin
                        n_dv = 1'b0;
                        if (!r_dv) begin
                            n_state = S_FINAL;
                        end
                    end
                end
            end

            S_FINAL: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_res   = '{status: ST_NOT_FOUND, found: 1'b0, link: '0, last: 1'b1};
                    n_state = S_IDLE;
                    case (t_op'(r_op))
                        OP_ADD: begin
                            if (r_hit) begin
                                n_res.status = ST_LINKED;
                                n_res.found  = 1'b1;
                                n_res.link   = r_hit_link;
                            end else if (r_count == CNT_BITS'(TABLE_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                // append at the end of the table
                                mem_req.we    = 1'b1;
                                mem_req.waddr = r_count[IDX_BITS-1:0];
                                mem_req.wdata = r_key;
                                n_count       = r_count + CNT_BITS'(1);
                                n_res.status  = ST_OK;
                                n_res.found   = 1'b1;
                                n_res.link    = r_key;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                n_res.status = ST_OK;
                                n_res.found  = 1'b1;
                                n_res.link   = r_hit_link;
                                // close the gap: move later entries down one place
                                n_ptr   = CNT_BITS'(r_hit_idx) + CNT_BITS'(1);
                                n_dv    = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        OP_FIND: begin
                            if (r_hit) begin
                                n_res.status = ST_OK;
                                n_res.found  = 1'b1;
                                n_res.link   = r_hit_link;
                            end
                        end
                        OP_LIST_SCENE, OP_LIST_PROV: begin
                            if (r_pend_v) begin
                                n_res.status = ST_OK;
                                n_res.found  = 1'b1;
                                n_res.link   = r_pend;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SHIFT: begin
                // entry read last cycle goes one place down
                if (r_dv) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_didx - IDX_BITS'(1);
                    mem_req.wdata = rd_data;
                end
                if (r_ptr < r_count) begin
                    mem_req.re = 1'b1;
                    n_ptr      = r_ptr + CNT_BITS'(1);
                    n_dv       = 1'b1;
                    n_didx     = r_ptr[IDX_BITS-1:0];
                end else begin
                    n_dv = 1'b0;
                    if (!r_dv) begin
                        n_count = r_count - CNT_BITS'(1);
                        n_state = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ptr    <= '0;
            r_dv     <= 1'b0;
            r_hit    <= 1'b0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ptr    <= n_ptr;
            r_dv     <= n_dv;
            r_hit    <= n_hit;
            r_pend_v <= n_pend_v;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_didx     <= n_didx;
        r_hit_idx  <= n_hit_idx;
        r_hit_link <= n_hit_link;
        r_pend     <= n_pend;
        r_res      <= n_res;
    end

    assign o_out.valid         = r_ov;
    assign o_out.status        = r_res.status;
    assign o_out.found         = r_res.found;
    assign o_out.link_provider = PORT_BITS'(r_res.link.provider);
    assign o_out.link_scene    = PORT_BITS'(r_res.link.scene);
    assign o_out.link_slot     = PORT_BITS'(r_res.link.slot);
    assign o_out.last          = r_res.last;

endmodule

`default_nettype wire

// ===== dv/buffer_link_table_chk.sv =====
module buffer_link_table_chk (
    input  logic i_clk,
    input  logic i_rst_n,
    blt_in_if    i_req_ch,
    blt_out_if   i_rsp_ch,
    output int   o_errors,
    output int   o_pending,
    output int   o_ops_seen,
    output int   o_results_seen,
    output int   o_longest_list,
    output int   o_full_refusals
);
    timeunit 1ns;
    timeprecision 1ps;

    import blt_pkg::*;

    localparam int SHOW_LIMIT = 10;

    t_link   links[$];          // mirror of the table, insertion order
    t_result results_due[$];    // expected results, oldest first

    int mismatch_count = 0;
    int due_count      = 0;
    int op_count       = 0;
    int result_count   = 0;
    int longest_list   = 0;
    int full_count     = 0;

    assign o_errors        = mismatch_count;
    assign o_pending       = due_count;
    assign o_ops_seen      = op_count;
    assign o_results_seen  = result_count;
    assign o_longest_list  = longest_list;
    assign o_full_refusals = full_count;

    function automatic t_result make_result(t_status st, logic hit, t_link lk);
        t_result r;
        r.status = st;
        r.found  = hit;
        r.link   = hit ? lk : '0;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic predict_links(input logic [OP_BITS-1:0]     op,
                                 input logic [HANDLE_BITS-1:0] prov,
                                 input logic [HANDLE_BITS-1:0] scene,
                                 input logic [HANDLE_BITS-1:0] slot);
        int      hit;
        t_link   lk;
        t_result burst[$];
        hit = -1;
        for (int k = 0; k < links.size(); k++) begin
            if (hit < 0 && links[k].scene == scene && links[k].slot == slot)
                hit = k;
        end
        lk.provider = prov;
        lk.scene    = scene;
        lk.slot     = slot;
        case (op)
            OP_ADD: begin
                // pair check wins over the full check
                if (hit >= 0) begin
                    burst = {burst, make_result(ST_LINKED, 1'b1, links[hit])};
                end else if (links.size() >= TABLE_DEPTH) begin
                    burst = {burst, make_result(ST_FULL, 1'b0, '0)};
                    full_count++;
                end else begin
                    links = {links, lk};
                    burst = {burst, make_result(ST_OK, 1'b1, lk)};
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    burst = {burst, make_result(ST_OK, 1'b1, links[hit])};
                    links.delete(hit);
                end
            end
            OP_FIND: begin
                if (hit >= 0)
                    burst = {burst, make_result(ST_OK, 1'b1, links[hit])};
            end
            OP_LIST_SCENE, OP_LIST_PROV: begin
                foreach (links[k]) begin
                    if ((op == OP_LIST_SCENE) ? (links[k].scene == scene)
                                              : (links[k].provider == prov))
                        burst = {burst, make_result(ST_OK, 1'b1, links[k])};
                end
                if (burst.size() > longest_list)
                    longest_list = burst.size();
            end
            default: ;
        endcase
        // no match and unused codes: one empty not-found result
        if (burst.size() == 0)
            burst = {burst, make_result(ST_NOT_FOUND, 1'b0, '0)};
        burst[burst.size()-1].last = 1'b1;
        results_due = {results_due, burst};
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.status        = t_status'(i_rsp_ch.status);
        got.found         = i_rsp_ch.found;
        got.link.provider = i_rsp_ch.link_provider;
        got.link.scene    = i_rsp_ch.link_scene;
        got.link.slot     = i_rsp_ch.link_slot;
        got.last          = i_rsp_ch.last;
        result_count++;
        if (results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
                $display("%0t: unexpected result st=%0d found=%0b p=%h sc=%h sl=%h last=%0b",
                         $realtime, got.status, got.found, got.link.provider,
                         got.link.scene, got.link.slot, got.last);
            return;
        end
        want = results_due.pop_front();
        if (got.status !== want.status || got.found !== want.found
                || got.link.provider !== want.link.provider
                || got.link.scene !== want.link.scene
                || got.link.slot !== want.link.slot || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT) begin
                $display("%0t: mismatch   got st=%0d found=%0b p=%h sc=%h sl=%h last=%0b",
                         $realtime, got.status, got.found, got.link.provider,
                         got.link.scene, got.link.slot, got.last);
                $display("%0t:       expected st=%0d found=%0b p=%h sc=%h sl=%h last=%0b",
                         $realtime, want.status, want.found, want.link.provider,
                         want.link.scene, want.link.slot, want.last);
            end
        end
    endtask

    // a result never leaves on the edge that took its request in, so the
    // output side is handled first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            links.delete();
            results_due.delete();
        end else begin
            if (i_rsp_ch.valid && i_rsp_ch.ready)
                check_result();
            if (i_req_ch.valid && i_req_ch.ready) begin
                op_count++;
                predict_links(i_req_ch.operation, i_req_ch.provider_buffer,
                              i_req_ch.scene_id, i_req_ch.slot_id);
            end
        end
        due_count = results_due.size();
    end

endmodule

// ===== dv/buffer_link_table_tb.sv =====
module buffer_link_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blt_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int LONG_HOLD    = 200;  // receiver hold-off while the table fills
    localparam int SETTLE       = 100;  // longer than the worst remove time
    localparam logic [HANDLE_BITS-1:0] H_MIN = '0;
    localparam logic [HANDLE_BITS-1:0] H_MAX = '1;
    // codes past the last real operation; the block must answer not-found
    localparam logic [OP_BITS-1:0] OP_BAD_FIRST = OP_BITS'(OP_LIST_PROV + 1);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    blt_in_if  req_ch ();
    blt_out_if rsp_ch ();

    // pacing controls shared by the two driving processes
    bit steady   = 1'b0;    // final stretch: no gaps on either side
    bit hold_req = 1'b0;    // ask the receiver for one long hold-off
    int held_cycles = 0;

    int chk_errors;
    int chk_pending;
    int chk_ops;
    int chk_results;
    int chk_longest;
    int chk_full;

    // handle pools keep remove/find/list hitting live entries
    logic [HANDLE_BITS-1:0] scene_pool[4];
    logic [HANDLE_BITS-1:0] slot_pool[5];
    logic [HANDLE_BITS-1:0] prov_pool[4];

    always #5ns clk = ~clk;

    buffer_link_table dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    buffer_link_table_chk link_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_ch        (req_ch),
        .i_rsp_ch        (rsp_ch),
        .o_errors        (chk_errors),
        .o_pending       (chk_pending),
        .o_ops_seen      (chk_ops),
        .o_results_seen  (chk_results),
        .o_longest_list  (chk_longest),
        .o_full_refusals (chk_full)
    );

    // Input gap: valid low, payload scrambled so stale fields
    // can't leak into a transfer.
    task automatic idle_req(input int n);
        repeat (n) begin
            @(negedge clk);
            req_ch.valid           = 1'b0;
            req_ch.operation       = OP_BITS'($urandom_range(0, 7));
            req_ch.provider_buffer = HANDLE_BITS'($urandom);
            req_ch.scene_id        = HANDLE_BITS'($urandom);
            req_ch.slot_id         = HANDLE_BITS'($urandom);
        end
    endtask

    // One request transfer. valid stays high into the next call when no gap
    // is drawn, so back-to-back requests see no bubble.
    task automatic offer_link_op(input logic [OP_BITS-1:0]     op,
                                 input logic [HANDLE_BITS-1:0] prov,
                                 input logic [HANDLE_BITS-1:0] scene,
                                 input logic [HANDLE_BITS-1:0] slot);
        if (!steady && $urandom_range(0, 3) == 0)
            idle_req($urandom_range(1, 14));
        @(negedge clk);
        req_ch.valid           = 1'b1;
        req_ch.operation       = op;
        req_ch.provider_buffer = prov;
        req_ch.scene_id        = scene;
        req_ch.slot_id         = slot;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Random op, weighted toward add so the table holds something worth
    // scanning. Mostly pooled handles; now and then fully random fields.
    task automatic random_link_op();
        logic [OP_BITS-1:0]     op;
        logic [HANDLE_BITS-1:0] p;
        logic [HANDLE_BITS-1:0] sc;
        logic [HANDLE_BITS-1:0] sl;
        int w;
        w = $urandom_range(0, 99);
        if (w < 35)      op = OP_ADD;
        else if (w < 55) op = OP_REMOVE;
        else if (w < 68) op = OP_FIND;
        else if (w < 80) op = OP_LIST_SCENE;
        else if (w < 93) op = OP_LIST_PROV;
        else             op = OP_BAD_FIRST + OP_BITS'($urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0) begin
            p  = HANDLE_BITS'($urandom);
            sc = HANDLE_BITS'($urandom);
            sl = HANDLE_BITS'($urandom);
        end else begin
            p  = prov_pool[$urandom_range(0, 3)];
            sc = scene_pool[$urandom_range(0, 3)];
            sl = slot_pool[$urandom_range(0, 4)];
        end
        offer_link_op(op, p, sc, sl);
    endtask

    // Receiver pacing: ready bursts and stall bursts, one long hold-off on
    // request, and ready held high once the final stretch starts.
    initial begin : rsp_pacing
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                rsp_ch.ready = 1'b0;
                held_cycles  = 0;
                while (held_cycles < LONG_HOLD) begin
                    @(negedge clk);
                    held_cycles++;
                end
                rsp_ch.ready = 1'b1;
                hold_req     = 1'b0;
            end else if (!steady && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end else begin
                rsp_ch.ready = 1'b1;
                if (!steady)
                    repeat ($urandom_range(0, 19)) @(negedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [HANDLE_BITS-1:0] fill_scene;
        logic [HANDLE_BITS-1:0] fill_prov;
        logic [HANDLE_BITS-1:0] fill_base;
        logic [HANDLE_BITS-1:0] fill_slots[$];
        logic [HANDLE_BITS-1:0] sl;
        int idx;

        req_ch.valid           = 1'b0;
        req_ch.operation       = OP_ADD;
        req_ch.provider_buffer = '0;
        req_ch.scene_id        = '0;
        req_ch.slot_id         = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        scene_pool = '{H_MIN, H_MAX, HANDLE_BITS'($urandom), HANDLE_BITS'($urandom)};
        slot_pool  = '{H_MIN, H_MAX, HANDLE_BITS'($urandom), HANDLE_BITS'($urandom),
                       HANDLE_BITS'($urandom)};
        prov_pool  = '{H_MIN, H_MAX, HANDLE_BITS'($urandom), HANDLE_BITS'($urandom)};

        // --- directed: empty table first, so every lookup misses
        offer_link_op(OP_FIND,       H_MIN, H_MIN, H_MIN);
        offer_link_op(OP_LIST_SCENE, H_MIN, H_MIN, H_MIN);
        offer_link_op(OP_LIST_PROV,  H_MAX, H_MAX, H_MAX);
        offer_link_op(OP_REMOVE,     H_MAX, H_MAX, H_MAX);
        // handle extremes; the fourth add hits an existing pair
        offer_link_op(OP_ADD, H_MIN,        H_MIN, H_MIN);
        offer_link_op(OP_ADD, H_MAX,        H_MAX, H_MAX);
        offer_link_op(OP_ADD, 16'h5a3c,     H_MIN, H_MAX);
        offer_link_op(OP_ADD, H_MAX,        H_MIN, H_MIN);
        offer_link_op(OP_ADD, H_MIN,        H_MAX, H_MIN);
        offer_link_op(OP_FIND, H_MIN, H_MAX, H_MAX);
        offer_link_op(OP_FIND, H_MIN, H_MIN, H_MAX);
        // multi-result lists, in insertion order
        offer_link_op(OP_LIST_SCENE, H_MIN, H_MIN, H_MIN);
        offer_link_op(OP_LIST_SCENE, H_MIN, H_MAX, H_MIN);
        offer_link_op(OP_LIST_PROV,  H_MAX, H_MIN, H_MIN);
        offer_link_op(OP_LIST_PROV,  H_MIN, H_MIN, H_MIN);
        // removing the head shifts the other three down
        offer_link_op(OP_REMOVE, H_MAX, H_MIN, H_MIN);
        offer_link_op(OP_REMOVE, H_MAX, H_MIN, H_MIN);
        offer_link_op(OP_FIND,   H_MIN, H_MIN, H_MIN);
        for (int k = 0; k < 3; k++)
            offer_link_op(OP_BAD_FIRST + OP_BITS'(k), HANDLE_BITS'($urandom),
                          HANDLE_BITS'($urandom), HANDLE_BITS'($urandom));
        offer_link_op(OP_LIST_SCENE, H_MIN, H_MAX, H_MIN);

        // --- random mix over small handle pools
        repeat (50) random_link_op();

        // --- fill: 40 distinct pairs under one scene guarantee a full table.
        // The receiver holds off meanwhile, so the block backs up and stalls
        // request transfers.
        fill_scene = HANDLE_BITS'($urandom);
        fill_prov  = HANDLE_BITS'($urandom);
        fill_base  = HANDLE_BITS'($urandom);
        hold_req   = 1'b1;
        for (int k = 0; k < 40; k++) begin
            sl = fill_base + HANDLE_BITS'(k);
            fill_slots = {fill_slots, sl};
            offer_link_op(OP_ADD, (k % 2 == 0) ? fill_prov : prov_pool[$urandom_range(0, 3)],
                          fill_scene, sl);
        end

        // --- full table: refusal, linked-before-full, longest lists
        offer_link_op(OP_ADD, fill_prov, fill_scene, fill_base + HANDLE_BITS'(40));
        offer_link_op(OP_ADD, HANDLE_BITS'($urandom), fill_scene, fill_slots[3]);
        offer_link_op(OP_LIST_SCENE, H_MIN, fill_scene, H_MIN);
        offer_link_op(OP_LIST_PROV, fill_prov, H_MIN, H_MIN);
        offer_link_op(OP_FIND, H_MIN, fill_scene, fill_slots[10]);
        offer_link_op(OP_ADD, HANDLE_BITS'($urandom), HANDLE_BITS'($urandom),
                      HANDLE_BITS'($urandom));

        // --- drain in random order; some pairs never made it in
        repeat (20) begin
            idx = $urandom_range(0, fill_slots.size() - 1);
            sl  = fill_slots[idx];
            fill_slots.delete(idx);
            offer_link_op(OP_REMOVE, H_MIN, fill_scene, sl);
        end
        repeat (10) random_link_op();

        // --- last stretch at full rate on both sides
        steady = 1'b1;
        repeat (25) random_link_op();

        @(negedge clk);
        req_ch.valid = 1'b0;
        wait (chk_pending == 0);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d requests and %0d results, all five operations plus unused codes.",
                 chk_ops, chk_results);
        $display("Longest list %0d results, %0d full-table refusals, %0d-cycle output hold-off.",
                 chk_longest, chk_full, held_cycles);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("Timed out with %0d results still due.", chk_pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
